/* src/ray_voxel_grid_traversal_unit_defines.svh */
// Assertion macros shared by the ray voxel walk RTL
`ifndef RAY_VOXEL_GRID_TRAVERSAL_UNIT_DEFINES_SVH
`define RAY_VOXEL_GRID_TRAVERSAL_UNIT_DEFINES_SVH

// Assert an implication sampled on clk, disabled in reset
`define RVG_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Assert a next-cycle implication sampled on clk, disabled in reset
`define RVG_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* src/rvg_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rvg_pkg
// Shared constants and types of the ray voxel walk.
// ----------------------------------------------------------------------------
package rvg_pkg;
  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned CFG_DATA_W = 31;
  localparam logic [CFG_IDX_W-1:0] REG_CELLS_X = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_CELLS_Y = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_CELLS_Z = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_WIDTH_X = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_WIDTH_Y = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_WIDTH_Z = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_EPS     = 3'd6;

  // Divider operands are 64-bit unsigned; quotients fit in 64 bits
  localparam int unsigned DIV_W = 64;

  typedef struct packed {
    logic start;
    logic busy;
    logic done;
  } div_ctl_t;
endpackage

/* src/ray_voxel_grid_traversal_unit.sv */
`timescale 1ns / 1ps
// Setup runs up to nine divisions on the shared divider (start cell, delta
// and first crossing per axis; an axis at or below epsilon needs only the
// first) before the first cell is presented. One ray at a time: a new ray is
// taken only after the last cell of the previous one is taken, and each
// further cell is computed after the previous one is taken.
// Reset: rst_n synchronous, active low; 16 cells, width 1.0, epsilon 1, idle.
// ----------------------------------------------------------------------------
// ray_voxel_grid_traversal_unit
// 3D DDA walk of a ray through a uniform voxel grid, Q16.16.
// ----------------------------------------------------------------------------
`include "ray_voxel_grid_traversal_unit_defines.svh"
module ray_voxel_grid_traversal_unit #(
  parameter int unsigned MAX_CELLS_PER_AXIS = 16,
  parameter int unsigned COORD_FRAC_BITS = 16
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_we,
  input  logic [rvg_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [rvg_pkg::CFG_DATA_W-1:0]   cfg_data,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic signed [31:0]               in_entry_x,
  input  logic signed [31:0]               in_entry_y,
  input  logic signed [31:0]               in_entry_z,
  input  logic signed [18:0]               in_dir_x,
  input  logic signed [18:0]               in_dir_y,
  input  logic signed [18:0]               in_dir_z,
  input  logic signed [31:0]               in_t_start,
  input  logic signed [31:0]               in_t_limit,
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic [3:0]                       out_cell_x,
  output logic [3:0]                       out_cell_y,
  output logic [3:0]                       out_cell_z,
  output logic [11:0]                      out_cell_address,
  output logic signed [31:0]               out_t_enter,
  output logic                             out_last
);
  localparam int unsigned W = rvg_pkg::DIV_W;
  localparam int unsigned MAXRES = 3 * (MAX_CELLS_PER_AXIS - 1) + 1;
  localparam int unsigned NW = $clog2(MAXRES + 1);
  localparam logic signed [33:0] SMAX = 34'sh0_7FFF_FFFF;
  localparam logic signed [33:0] SMIN = -34'sh0_8000_0000;

  typedef enum logic [2:0] {
    ST_IDLE, ST_CELL, ST_DELTA, ST_NEXT, ST_WAIT, ST_EMIT, ST_OUT
  } state_t;
  typedef enum logic [1:0] { PH_CELL, PH_DELTA, PH_NEXT } phase_t;

  // Configuration registers
  logic [4:0]  cells_r [3];
  logic [30:0] width_r [3];
  logic [15:0] eps_r;

  // Ray registers
  logic signed [31:0] ent_r [3];
  logic signed [18:0] dir_r [3];
  logic signed [31:0] t0_r, tlim_r;
  logic [4:0]  pos_r [3];
  logic signed [31:0] nxt_r [3];
  logic [31:0] dlt_r [3];
  logic [2:0]  neg_r, act_r;
  logic signed [31:0] cur_r;
  logic [NW-1:0] n_r;
  logic [1:0]  ax_r;
  phase_t      ph_r;
  state_t      st_r;
  logic        div_start;
  logic [W-1:0] div_a, div_b, div_q;
  rvg_pkg::div_ctl_t dctl;

  logic [4:0]  ec [3];
  logic [31:0] ew [3];
  logic [18:0] mag [3];
  logic [1:0]  best;
  logic        has_best, stop;
  logic signed [33:0] sum_s;
  logic [4:0]  new_pos;

  logic [W-1:0] q_sat;
  logic [35:0] g_lo;
  logic signed [37:0] ent_s, lo_s, hi_s, diff;
  logic [37:0] diff_mag;
  logic signed [34:0] q_s;
  logic signed [35:0] ns;
  logic signed [31:0] nxt_init;

  rvg_divider u_div (
    .clk(clk), .rst_n(rst_n), .start(div_start), .dividend(div_a),
    .divisor(div_b), .ctl(dctl), .quotient(div_q)
  );

  // Effective counts, widths and direction magnitudes
  always_comb begin
    for (int a = 0; a < 3; a++) begin
      if (cells_r[a] == 5'd0) ec[a] = 5'd1;
      else if (32'(cells_r[a]) > MAX_CELLS_PER_AXIS) ec[a] = 5'(MAX_CELLS_PER_AXIS);
      else ec[a] = cells_r[a];
      ew[a] = (width_r[a] == '0) ? 32'd1 : {1'b0, width_r[a]};
      mag[a] = dir_r[a][18] ? 19'(-dir_r[a]) : 19'(dir_r[a]);
    end
  end

  // Divider operands for the current axis and phase
  always_comb begin
    div_b = W'(mag[ax_r]);
    div_a = '0;
    unique case (ph_r)
      PH_CELL: begin
        div_a = ent_r[ax_r][31] ? '0 : W'(ent_r[ax_r]);
        div_b = W'(ew[ax_r]);
      end
      PH_DELTA: div_a = W'(ew[ax_r]) << COORD_FRAC_BITS;
      PH_NEXT: div_a = W'(diff_mag) << COORD_FRAC_BITS;
      default: div_a = '0;
    endcase
  end
  assign div_start = (st_r == ST_CELL) || (st_r == ST_DELTA) || (st_r == ST_NEXT);

  // Pick the stepping axis; ties favor x, then y
  always_comb begin
    best = 2'd0;
    has_best = 1'b0;
    for (int a = 0; a < 3; a++) begin
      if (act_r[a] && (!has_best || nxt_r[a] < nxt_r[best])) begin
        best = 2'(a);
        has_best = 1'b1;
      end
    end
    sum_s = 34'(nxt_r[best]) + 34'(signed'({2'b00, dlt_r[best]}));
    new_pos = neg_r[best] ? pos_r[best] - 5'd1 : pos_r[best] + 5'd1;
    stop = !has_best || (32'(n_r) + 1 >= MAXRES) ||
           (neg_r[best] ? new_pos == 5'h1F : new_pos == ec[best]) ||
           (nxt_r[best] > tlim_r);
  end

  // Configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int a = 0; a < 3; a++) begin
        cells_r[a] <= 5'd16;
        width_r[a] <= 31'd65536;
      end
      eps_r <= 16'd1;
    end else if (cfg_we) begin
      unique case (cfg_index)
        rvg_pkg::REG_CELLS_X: cells_r[0] <= cfg_data[4:0];
        rvg_pkg::REG_CELLS_Y: cells_r[1] <= cfg_data[4:0];
        rvg_pkg::REG_CELLS_Z: cells_r[2] <= cfg_data[4:0];
        rvg_pkg::REG_WIDTH_X: width_r[0] <= cfg_data;
        rvg_pkg::REG_WIDTH_Y: width_r[1] <= cfg_data;
        rvg_pkg::REG_WIDTH_Z: width_r[2] <= cfg_data;
        rvg_pkg::REG_EPS:     eps_r <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  // Distance to the next boundary and the saturated first crossing
  always_comb begin
    q_sat = div_q;
    g_lo = 36'(pos_r[ax_r]) * 36'(ew[ax_r]);
    ent_s = 38'(ent_r[ax_r]);
    lo_s = signed'({2'b00, g_lo});
    hi_s = lo_s + signed'({6'd0, ew[ax_r]});
    diff = neg_r[ax_r] ? ent_s - lo_s : hi_s - ent_s;
    diff_mag = diff[37] ? unsigned'(-diff) : unsigned'(diff);
    q_s = diff[37] ? -signed'({2'b00, div_q[32:0]}) : signed'({2'b00, div_q[32:0]});
    ns = 36'(t0_r) + 36'(q_s);
    if (|div_q[W-1:33]) nxt_init = diff[37] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
    else if (ns > 36'(SMAX)) nxt_init = 32'sh7FFF_FFFF;
    else if (ns < 36'(SMIN)) nxt_init = 32'sh8000_0000;
    else nxt_init = 32'(ns);
  end

  // Sequencer: per-axis setup through the divider, then the walk
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= ST_IDLE;
      out_valid <= 1'b0;
      ax_r <= 2'd0;
      ph_r <= PH_CELL;
      n_r <= '0;
    end else begin
      unique case (st_r)
        ST_IDLE: if (in_valid) begin
          ent_r[0] <= in_entry_x; ent_r[1] <= in_entry_y; ent_r[2] <= in_entry_z;
          dir_r[0] <= in_dir_x; dir_r[1] <= in_dir_y; dir_r[2] <= in_dir_z;
          t0_r <= in_t_start; tlim_r <= in_t_limit; cur_r <= in_t_start;
          ax_r <= 2'd0; ph_r <= PH_CELL; n_r <= '0;
          st_r <= ST_CELL;
        end
        ST_CELL, ST_DELTA, ST_NEXT: st_r <= ST_WAIT;
        ST_WAIT: if (dctl.done) begin
          unique case (ph_r)
            PH_CELL: begin
              if (|q_sat[W-1:5] || q_sat[4:0] >= ec[ax_r])
                pos_r[ax_r] <= ec[ax_r] - 5'd1;
              else pos_r[ax_r] <= q_sat[4:0];
              if ({13'd0, mag[ax_r]} <= {16'd0, eps_r}) begin
                act_r[ax_r] <= 1'b0;
                neg_r[ax_r] <= 1'b0;
                if (ax_r == 2'd2) st_r <= ST_EMIT;
                else begin ax_r <= ax_r + 2'd1; st_r <= ST_CELL; end
              end else begin
                act_r[ax_r] <= 1'b1;
                neg_r[ax_r] <= dir_r[ax_r][18];
                ph_r <= PH_DELTA; st_r <= ST_DELTA;
              end
            end
            PH_DELTA: begin
              dlt_r[ax_r] <= (|q_sat[W-1:31]) ? 32'h7FFF_FFFF : q_sat[31:0];
              ph_r <= PH_NEXT; st_r <= ST_NEXT;
            end
            PH_NEXT: begin
              nxt_r[ax_r] <= nxt_init;
              ph_r <= PH_CELL;
              if (ax_r == 2'd2) st_r <= ST_EMIT;
              else begin ax_r <= ax_r + 2'd1; st_r <= ST_CELL; end
            end
            default: st_r <= ST_IDLE;
          endcase
        end
        ST_EMIT: begin
          out_cell_x <= pos_r[0][3:0];
          out_cell_y <= pos_r[1][3:0];
          out_cell_z <= pos_r[2][3:0];
          out_cell_address <= 12'(({7'd0, pos_r[0]} * {7'd0, ec[1]} + {7'd0, pos_r[1]}) *
                              {7'd0, ec[2]} + {7'd0, pos_r[2]});
          out_t_enter <= cur_r;
          out_last <= stop;
          out_valid <= 1'b1;
          n_r <= n_r + 1'b1;
          if (!stop) begin
            pos_r[best] <= new_pos;
            nxt_r[best] <= sum_s > SMAX ? 32'sh7FFF_FFFF :
                           (sum_s < SMIN ? 32'sh8000_0000 : 32'(sum_s));
            cur_r <= nxt_r[best];
          end
          st_r <= ST_OUT;
        end
        ST_OUT: if (!out_stall) begin
          out_valid <= 1'b0;
          st_r <= out_last ? ST_IDLE : ST_EMIT;
        end
        default: st_r <= ST_IDLE;
      endcase
    end
  end

  assign in_stall = (st_r != ST_IDLE);

  `RVG_ASSERT_IMP(a_busy_stall, out_valid, in_stall, "output pending while input open")
  `RVG_ASSERT_NXT(a_div_start, div_start, dctl.busy, "divider did not start")
  `RVG_ASSERT_IMP(a_emit_div_idle, st_r == ST_EMIT, !dctl.busy, "walk during divide")
endmodule

/* src/rvg_divider.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rvg_divider
// Shared restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module rvg_divider (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  input  logic [rvg_pkg::DIV_W-1:0]     dividend,
  input  logic [rvg_pkg::DIV_W-1:0]     divisor,
  output rvg_pkg::div_ctl_t             ctl,
  output logic [rvg_pkg::DIV_W-1:0]     quotient
);
  localparam int unsigned W = rvg_pkg::DIV_W;
  localparam int unsigned CW = $clog2(W + 1);

  logic [W-1:0]  q_r, q_nxt;
  logic [W-1:0]  rem_r, rem_nxt;
  logic [W-1:0]  dsr_r, dsr_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic          busy_r, busy_nxt;
  logic          done_r, done_nxt;
  logic [W:0]    trial;
  logic [W:0]    shifted;

  // Load the operands on start, else compute one quotient bit
  always_comb begin
    q_nxt = q_r;
    rem_nxt = rem_r;
    dsr_nxt = dsr_r;
    cnt_nxt = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    shifted = {rem_r, q_r[W-1]};
    trial = shifted - {1'b0, dsr_r};
    if (start) begin
      q_nxt = dividend;
      rem_nxt = '0;
      dsr_nxt = divisor;
      cnt_nxt = CW'(W);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (!trial[W]) begin
        rem_nxt = trial[W-1:0];
        q_nxt = {q_r[W-2:0], 1'b1};
      end else begin
        rem_nxt = shifted[W-1:0];
        q_nxt = {q_r[W-2:0], 1'b0};
      end
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == CW'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    q_r <= q_nxt;
    rem_r <= rem_nxt;
    dsr_r <= dsr_nxt;
    cnt_r <= cnt_nxt;
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
  end

  assign quotient = q_r;
  assign ctl.start = start;
  assign ctl.busy = busy_r;
  assign ctl.done = done_r;
endmodule

/* dv/rvg_walk_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rvg_walk_checker
// Watches the ray and cell channels of the voxel walk unit. It mirrors the
// register writes, predicts the cells each accepted ray crosses and compares
// every accepted cell transaction, field by field, with the oldest one due.
// ----------------------------------------------------------------------------
module rvg_walk_checker (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_we,
  input  logic [rvg_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [rvg_pkg::CFG_DATA_W-1:0] cfg_data,
  input  logic                           in_valid,
  input  logic                           in_stall,
  input  logic signed [31:0]             in_entry_x,
  input  logic signed [31:0]             in_entry_y,
  input  logic signed [31:0]             in_entry_z,
  input  logic signed [18:0]             in_dir_x,
  input  logic signed [18:0]             in_dir_y,
  input  logic signed [18:0]             in_dir_z,
  input  logic signed [31:0]             in_t_start,
  input  logic signed [31:0]             in_t_limit,
  input  logic                           out_valid,
  input  logic                           out_stall,
  input  logic [3:0]                     out_cell_x,
  input  logic [3:0]                     out_cell_y,
  input  logic [3:0]                     out_cell_z,
  input  logic [11:0]                    out_cell_address,
  input  logic signed [31:0]             out_t_enter,
  input  logic                           out_last,
  output int                             fail_count,
  output int                             cells_due,
  output int                             cells_seen
);
  localparam int MAX_AXIS_CELLS = 16;
  localparam int MAX_CELLS_PER_RAY = 3 * (MAX_AXIS_CELLS - 1) + 1;
  localparam int FRAC_BITS = 16;

  typedef struct {
    logic [3:0]         cx;
    logic [3:0]         cy;
    logic [3:0]         cz;
    logic [11:0]        addr;
    logic signed [31:0] t_enter;
    logic               last;
  } crossed_cell_t;

  crossed_cell_t cell_q[$];

  // mirrored registers
  logic [4:0]  grid_cells[3];
  logic [30:0] voxel_w[3];
  logic [15:0] eps;

  function automatic longint clip32(longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  // Walk one ray through the grid and queue every cell it crosses
  function automatic void walk_ray(logic signed [31:0] ent[3], logic signed [18:0] dv[3],
                                   logic signed [31:0] t0, logic signed [31:0] tlim);
    longint        p, d, mag, w, g, diff;
    longint        nxt[3], dlt[3], cur, t;
    int            cp[3], ext[3], cl[3];
    bit            neg[3], act[3], stop;
    int            best, n;
    crossed_cell_t c;
    for (int a = 0; a < 3; a++) begin
      p = ent[a];
      d = dv[a];
      mag = (d < 0) ? -d : d;
      w = (voxel_w[a] == 0) ? 1 : longint'(voxel_w[a]);
      cl[a] = (grid_cells[a] == 0) ? 1 :
              (grid_cells[a] > MAX_AXIS_CELLS) ? MAX_AXIS_CELLS : int'(grid_cells[a]);
      g = (p < 0) ? 0 : p / w;
      if (g >= cl[a]) g = cl[a] - 1;
      cp[a] = int'(g);
      if (mag <= longint'(eps)) begin
        act[a] = 0; dlt[a] = 0; nxt[a] = 0; neg[a] = 0; ext[a] = cl[a];
      end else begin
        act[a] = 1;
        dlt[a] = clip32((w <<< FRAC_BITS) / mag);
        if (d > 0) begin
          diff = (g + 1) * w - p; neg[a] = 0; ext[a] = cl[a];
        end else begin
          diff = p - g * w; neg[a] = 1; ext[a] = -1;
        end
        nxt[a] = clip32(longint'(t0) + (diff <<< FRAC_BITS) / mag);
      end
    end
    cur = t0;
    n = 0;
    forever begin
      c.cx = cp[0][3:0];
      c.cy = cp[1][3:0];
      c.cz = cp[2][3:0];
      c.addr = 12'((cp[0] * cl[1] + cp[1]) * cl[2] + cp[2]);
      c.t_enter = cur[31:0];
      c.last = 0;
      n++;
      best = -1;
      stop = 0;
      for (int a = 0; a < 3; a++)
        if (act[a] && (best < 0 || nxt[a] < nxt[best])) best = a;
      if (best < 0 || n >= MAX_CELLS_PER_RAY) begin
        stop = 1;
      end else begin
        t = nxt[best];
        cp[best] += neg[best] ? -1 : 1;
        nxt[best] = clip32(t + dlt[best]);
        cur = t;
        if (cp[best] == ext[best] || t > tlim) stop = 1;
      end
      c.last = stop;
      cell_q.push_back(c);
      if (stop) break;
    end
  endfunction

  always @(posedge clk) begin
    logic signed [31:0] ent[3];
    logic signed [18:0] dv[3];
    crossed_cell_t      e;
    if (!rst_n) begin
      for (int a = 0; a < 3; a++) begin
        grid_cells[a] = 5'd16;
        voxel_w[a] = 31'd65536;
      end
      eps = 16'd1;
    end else begin
      // mirror register writes
      if (cfg_we) begin
        case (cfg_index)
          rvg_pkg::REG_CELLS_X: grid_cells[0] = cfg_data[4:0];
          rvg_pkg::REG_CELLS_Y: grid_cells[1] = cfg_data[4:0];
          rvg_pkg::REG_CELLS_Z: grid_cells[2] = cfg_data[4:0];
          rvg_pkg::REG_WIDTH_X: voxel_w[0] = cfg_data;
          rvg_pkg::REG_WIDTH_Y: voxel_w[1] = cfg_data;
          rvg_pkg::REG_WIDTH_Z: voxel_w[2] = cfg_data;
          rvg_pkg::REG_EPS:     eps = cfg_data[15:0];
          default: ;
        endcase
      end
      // predict on each accepted ray
      if (in_valid && !in_stall) begin
        ent[0] = in_entry_x; ent[1] = in_entry_y; ent[2] = in_entry_z;
        dv[0] = in_dir_x; dv[1] = in_dir_y; dv[2] = in_dir_z;
        walk_ray(ent, dv, in_t_start, in_t_limit);
      end
      // compare each accepted cell
      if (out_valid && !out_stall) begin
        cells_seen++;
        if (cell_q.size() == 0) begin
          $error("cell transaction with nothing expected");
          fail_count++;
        end else begin
          e = cell_q.pop_front();
          if (out_cell_x !== e.cx) begin
            $error("cell_x: expected %0d, got %0d", e.cx, out_cell_x); fail_count++;
          end
          if (out_cell_y !== e.cy) begin
            $error("cell_y: expected %0d, got %0d", e.cy, out_cell_y); fail_count++;
          end
          if (out_cell_z !== e.cz) begin
            $error("cell_z: expected %0d, got %0d", e.cz, out_cell_z); fail_count++;
          end
          if (out_cell_address !== e.addr) begin
            $error("cell_address: expected %0d, got %0d", e.addr, out_cell_address);
            fail_count++;
          end
          if (out_t_enter !== e.t_enter) begin
            $error("t_enter: expected %0d, got %0d", e.t_enter, out_t_enter); fail_count++;
          end
          if (out_last !== e.last) begin
            $error("last: expected %0d, got %0d", e.last, out_last); fail_count++;
          end
        end
      end
    end
    cells_due = cell_q.size();
  end
endmodule

/* dv/tb_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Stimulus for the voxel walk unit: directed rays over the special cases,
// then random rays over several grid settings, with random idling on both
// channels, one long receiver hold-off and drain pauses.
// ----------------------------------------------------------------------------
module tb_top;
  localparam int IDLE_LIMIT = 6000;
  localparam int HOLD_CYCLES = 400;
  localparam int unsigned DATA_W = rvg_pkg::CFG_DATA_W;

  logic clk = 0;
  logic rst_n = 0;
  logic cfg_we = 0;
  logic [rvg_pkg::CFG_IDX_W-1:0] cfg_index = '0;
  logic [rvg_pkg::CFG_DATA_W-1:0] cfg_data = '0;
  logic in_valid = 0;
  logic in_stall;
  logic signed [31:0] in_entry_x = 0, in_entry_y = 0, in_entry_z = 0;
  logic signed [18:0] in_dir_x = 0, in_dir_y = 0, in_dir_z = 0;
  logic signed [31:0] in_t_start = 0, in_t_limit = 0;
  logic out_valid;
  logic out_stall = 1;
  logic [3:0] out_cell_x, out_cell_y, out_cell_z;
  logic [11:0] out_cell_address;
  logic signed [31:0] out_t_enter;
  logic out_last;

  int fail_count, cells_due, cells_seen;
  int rays_sent = 0;
  int idle_cycles = 0;
  bit no_idle = 0;
  bit hold_req = 0;
  bit hold_done = 0;
  bit sim_done = 0;

  // grid as last written, for shaping well-formed rays
  int     grid_n[3];
  longint grid_w[3];

  always #5 clk = ~clk;

  ray_voxel_grid_traversal_unit uut (
    .clk(clk), .rst_n(rst_n),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_stall(in_stall),
    .in_entry_x(in_entry_x), .in_entry_y(in_entry_y), .in_entry_z(in_entry_z),
    .in_dir_x(in_dir_x), .in_dir_y(in_dir_y), .in_dir_z(in_dir_z),
    .in_t_start(in_t_start), .in_t_limit(in_t_limit),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_cell_x(out_cell_x), .out_cell_y(out_cell_y), .out_cell_z(out_cell_z),
    .out_cell_address(out_cell_address), .out_t_enter(out_t_enter), .out_last(out_last)
  );

  rvg_walk_checker u_checker (
    .clk(clk), .rst_n(rst_n),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_stall(in_stall),
    .in_entry_x(in_entry_x), .in_entry_y(in_entry_y), .in_entry_z(in_entry_z),
    .in_dir_x(in_dir_x), .in_dir_y(in_dir_y), .in_dir_z(in_dir_z),
    .in_t_start(in_t_start), .in_t_limit(in_t_limit),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_cell_x(out_cell_x), .out_cell_y(out_cell_y), .out_cell_z(out_cell_z),
    .out_cell_address(out_cell_address), .out_t_enter(out_t_enter), .out_last(out_last),
    .fail_count(fail_count), .cells_due(cells_due), .cells_seen(cells_seen)
  );

  // Watchdog: give up when nothing moves for too long
  always @(posedge clk) begin
    if (!sim_done) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("timeout: no transaction for %0d cycles", IDLE_LIMIT);
        $display("*** FAILED ***");
        $finish;
      end
    end
  end

  // Cell receiver: random stalls, bursts without stalls, one long hold-off
  initial begin
    int gap;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      if (hold_req && !hold_done) begin
        hold_done = 1;
        out_stall = 1;
        repeat (HOLD_CYCLES) @(negedge clk);
      end
      gap = no_idle ? 0 : $urandom_range(0, 4);
      if (gap > 0) begin
        out_stall = 1;
        repeat (gap) @(negedge clk);
      end
      out_stall = 0;
      do @(posedge clk); while (!out_valid);
    end
  end

  task automatic write_reg(logic [rvg_pkg::CFG_IDX_W-1:0] idx,
                           logic [rvg_pkg::CFG_DATA_W-1:0] val);
    @(negedge clk);
    cfg_we = 1;
    cfg_index = idx;
    cfg_data = val;
    @(negedge clk);
    cfg_we = 0;
    case (idx)
      rvg_pkg::REG_CELLS_X, rvg_pkg::REG_CELLS_Y, rvg_pkg::REG_CELLS_Z:
        grid_n[idx] = (val[4:0] == 0) ? 1 : (val[4:0] > 16) ? 16 : int'(val[4:0]);
      rvg_pkg::REG_WIDTH_X, rvg_pkg::REG_WIDTH_Y, rvg_pkg::REG_WIDTH_Z:
        grid_w[idx - rvg_pkg::REG_WIDTH_X] = (val == 0) ? 1 : longint'(val);
      default: ;
    endcase
  endtask

  task automatic set_grid(int nx, int ny, int nz, longint wx, longint wy, longint wz,
                          int eps);
    write_reg(rvg_pkg::REG_CELLS_X, DATA_W'(nx));
    write_reg(rvg_pkg::REG_CELLS_Y, DATA_W'(ny));
    write_reg(rvg_pkg::REG_CELLS_Z, DATA_W'(nz));
    write_reg(rvg_pkg::REG_WIDTH_X, DATA_W'(wx));
    write_reg(rvg_pkg::REG_WIDTH_Y, DATA_W'(wy));
    write_reg(rvg_pkg::REG_WIDTH_Z, DATA_W'(wz));
    write_reg(rvg_pkg::REG_EPS, DATA_W'(eps));
  endtask

  // Offer one ray, hold it until accepted, then idle a random gap
  task automatic send_ray(logic signed [31:0] ex, ey, ez, logic signed [18:0] dx, dy, dz,
                          logic signed [31:0] ts, tl);
    int gap;
    in_entry_x = ex; in_entry_y = ey; in_entry_z = ez;
    in_dir_x = dx; in_dir_y = dy; in_dir_z = dz;
    in_t_start = ts; in_t_limit = tl;
    in_valid = 1;
    do @(posedge clk); while (in_stall);
    rays_sent++;
    @(negedge clk);
    gap = no_idle ? 0 : $urandom_range(0, 4);
    if (gap > 0) begin
      in_valid = 0;
      repeat (gap) @(negedge clk);
    end
  endtask

  // Stop offering and wait until every predicted cell has arrived
  task automatic drain();
    in_valid = 0;
    while (cells_due != 0) @(negedge clk);
    repeat (20) @(negedge clk);
  endtask

  function automatic logic signed [18:0] rand_dir();
    case ($urandom_range(0, 9))
      0: return 19'sd0;
      1: return 19'sd131072;
      2: return -19'sd131072;
      default: return 19'($signed($urandom_range(0, 262144)) - 131072);
    endcase
  endfunction

  function automatic logic signed [31:0] rand_entry(int a);
    longint span;
    span = grid_n[a] * grid_w[a];
    if (span > 64'sd2147483647) span = 64'sd2147483647;
    return 32'($urandom_range(0, 32'(span - 1)));
  endfunction

  // Mostly well-formed rays inside the grid, the rest raw noise
  task automatic random_rays(int count);
    logic signed [31:0] ts, tl;
    for (int i = 0; i < count; i++) begin
      if ($urandom_range(0, 5) == 0) begin
        send_ray($urandom, $urandom, $urandom, rand_dir(), rand_dir(), rand_dir(),
                 $urandom, $urandom);
      end else begin
        ts = 32'($urandom_range(0, 32'h40000));
        tl = ($urandom_range(0, 3) == 0) ? ts + 32'($urandom_range(0, 32'h80000))
                                         : 32'sh7fffffff;
        send_ray(rand_entry(0), rand_entry(1), rand_entry(2),
                 rand_dir(), rand_dir(), rand_dir(), ts, tl);
      end
    end
  endtask

  initial begin
    for (int a = 0; a < 3; a++) begin
      grid_n[a] = 16;
      grid_w[a] = 65536;
    end
    repeat (9) @(negedge clk);
    rst_n = 1;
    @(negedge clk);

    // Directed rays on the reset grid: single axes, ties, degenerate cases
    no_idle = 1;
    send_ray(32'sh8000, 32'sh8000, 32'sh8000, 19'sd65536, 19'sd0, 19'sd0, 0, 32'sh7fffffff);
    send_ray(32'shf8000, 32'sh8000, 32'sh8000, -19'sd65536, 19'sd0, 19'sd0, 0, 32'sh7fffffff);
    send_ray(32'sh8000, 32'sh8000, 32'sh8000, 19'sd0, 19'sd65536, 19'sd0, 100, 32'sh7fffffff);
    send_ray(32'sh8000, 32'sh8000, 32'shf8000, 19'sd0, 19'sd0, -19'sd65536, 0, 32'sh7fffffff);
    send_ray(32'sh8000, 32'sh8000, 32'sh8000, 19'sd65536, 19'sd65536, 19'sd65536, 0,
             32'sh7fffffff);
    send_ray(0, 0, 0, 19'sd131072, 19'sd131072, 19'sd131072, 32'sh7fffffff, 32'sh7fffffff);
    send_ray(32'sh8000, 32'sh8000, 32'sh8000, 19'sd1, -19'sd1, 19'sd0, 0, 32'sh7fffffff);
    send_ray(32'sh8000, 32'sh8000, 32'sh8000, 19'sd2, -19'sd2, 19'sd2, 0, 32'sh7fffffff);
    send_ray(32'sh8000, 32'sh8000, 32'sh8000, 19'sd65536, 19'sd0, 19'sd0, 1000, 0);
    send_ray(32'sh80000000, 32'sh7fffffff, -1, 19'sd65536, -19'sd65536, 19'sd3000,
             -32'sh10000, 32'sh7fffffff);
    send_ray(32'sh7fffffff, 32'sh80000000, 32'sh7fffffff, -19'sd131072, 19'sd131072,
             -19'sd131072, 32'sh80000000, 32'sh80000000);
    send_ray(32'sh8000, 32'sh8000, 32'sh8000, 19'sd40000, 19'sd30000, 19'sd20000, 0,
             32'sh30000);
    no_idle = 0;
    drain();

    // Extremes of the registers: one-cell axis, zero and huge widths, eps 0
    set_grid(1, 16, 0, 1, 31'h7fffffff, 0, 0);
    send_ray(0, 32'sh10000, 5, 19'sd1, -19'sd1, 19'sd131072, 0, 32'sh7fffffff);
    send_ray(32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff, 19'sd131072, 19'sd1, -19'sd1,
             0, 32'sh7fffffff);
    send_ray(-5, 0, 0, -19'sd100, 19'sd131072, 19'sd50, 32'sh7ffff000, 32'sh7fffffff);
    drain();
    set_grid(31, 17, 16, 31'h20000, 31'h8000, 31'h10000, 65535);
    send_ray(32'sh8000, 32'sh8000, 32'sh8000, 19'sd65535, 19'sd65536, -19'sd131072, 0,
             32'sh7fffffff);
    send_ray(32'sh8000, 32'sh8000, 32'sh8000, 19'sd131072, -19'sd131072, 19'sd65535, 0,
             32'sh7fffffff);
    send_ray(32'sh8000, 32'sh8000, 32'sh8000, 19'sd1000, 19'sd0, -19'sd1000, 0, 32'sh7fffffff);
    drain();

    // Random grids with random rays; the second one carries the long hold-off
    for (int ph = 0; ph < 6; ph++) begin
      set_grid($urandom_range(1, 16), $urandom_range(1, 16), $urandom_range(1, 16),
               $urandom_range(32'h1000, 32'h40000), $urandom_range(32'h1000, 32'h40000),
               $urandom_range(32'h1000, 32'h40000),
               ($urandom_range(0, 2) == 0) ? $urandom_range(0, 65535) : $urandom_range(0, 64));
      no_idle = (ph == 4);
      if (ph == 1) hold_req = 1;
      random_rays(18);
      drain();
    end
    no_idle = 0;

    while (cells_due != 0) @(negedge clk);
    repeat (100) @(negedge clk);
    sim_done = 1;
    $display("Covered %0d rays and %0d crossed cells over reset, extreme and random grids,",
             rays_sent, cells_seen);
    $display("with random idling, one long output hold-off and drain pauses.");
    if (fail_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end
endmodule
